// ----- src/dmx512_frame_transceiver_macros.svh -----
// Assertion macros used by the transceiver RTL.
`ifndef DMX512_FRAME_TRANSCEIVER_MACROS_SVH
`define DMX512_FRAME_TRANSCEIVER_MACROS_SVH

`ifndef ASSERT_OFF

`define DMXFT_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dmxft assertion failed: invariant");

`define DMXFT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmxft assertion failed: same-cycle implication");

`define DMXFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmxft assertion failed: next-cycle implication");

`else

`define DMXFT_ASSERT_HOLDS(label, clk, rst, cond)
`define DMXFT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DMXFT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/dmxft_pkg.sv -----
// Types and constants for the DMX512 frame transceiver.
package dmxft_pkg;

   localparam int SLOT_COUNT_DEFAULT = 512;
   localparam int MIN_SLOTS          = 24;

   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_TX  = 2'd1;
   localparam logic [1:0] MODE_RX  = 2'd2;

   localparam logic REG_MODE      = 1'b0;
   localparam logic REG_MAX_SLOTS = 1'b1;

   typedef enum logic [1:0] {
      ACT_HOST_WR = 2'd0,
      ACT_HOST_RD = 2'd1,
      ACT_TX_DONE = 2'd2,
      ACT_RX_BYTE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_BREAK = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_IDLE  = 2'd3
   } phase_type;

   // one access to the slot memory
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] wdata;
   } ram_req_type;

   // request in flight while its memory read completes
   typedef struct packed {
      logic       rd_sel;
      logic       tx_valid;
      logic       tx_sel;
      logic       brk;
      logic       done;
      logic [9:0] slots;
   } stage_type;

endpackage

// ----- src/dmx512_frame_transceiver.sv -----
// After a request is accepted, its result passes the memory read stage and then the output register.
// Throughput: one request per cycle unless the output stalls, each with at most one access to the
// single-port slot memory. Reset: synchronous; afterwards a sweep of all SLOT_COUNT+1 entries
// (513 by default) zeroes the memory while req_tready stays low. The register port is served throughout.
// Reset state: mode off, max_slots 512 (or SLOT_COUNT if lower), phase break, counter zero.
`include "dmx512_frame_transceiver_macros.svh"

module dmx512_frame_transceiver #(
   parameter int SLOT_COUNT = dmxft_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // slot_index[9:0], data_byte[17:10], frame_error[18], zero
   input  logic [1:0]  req_tuser,  // action[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                   // break_format[17], frame_done[18], frame_slots[28:19], zero
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dmxft_pkg::*;

   localparam int AW = $clog2(SLOT_COUNT + 1);
   localparam logic [9:0] SLOT_LAST = 10'(SLOT_COUNT);
   localparam logic [9:0] SLOTS_MIN = 10'(MIN_SLOTS);
   localparam logic [9:0] SLOTS_RST = (SLOT_COUNT < 512) ? 10'(SLOT_COUNT) : 10'd512;

   // registers
   logic [1:0]  mode_ff, mode_in;
   logic [9:0]  max_slots_ff, max_slots_in;
   phase_type   phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff, s1_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;

   // request decode
   action_type  action;
   logic [9:0]  slot_index;
   logic [7:0]  data_byte;
   logic        frame_error;
   logic        req_fire;
   logic        s1_move;
   logic        cfg_wr;
   logic [9:0]  cfg_slots;
   logic [9:0]  count_inc;
   logic [9:0]  mem_addr;
   ram_req_type ram_req;
   logic [7:0]  ram_rdata;
   logic        clr_busy;
   logic [7:0]  rd_val;
   logic [7:0]  tx_val;

   assign action      = action_type'(req_tuser);
   assign slot_index  = req_tdata[9:0];
   assign data_byte   = req_tdata[17:10];
   assign frame_error = req_tdata[18];

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_move);
   assign req_fire   = req_tvalid && req_tready;
   assign count_inc  = count_ff + 10'd1;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // clamp the slot count written by the host
   always_comb begin
      cfg_slots = csr_pwdata[9:0];
      if (cfg_slots < SLOTS_MIN) begin
         cfg_slots = SLOTS_MIN;
      end else if (cfg_slots > SLOT_LAST) begin
         cfg_slots = SLOT_LAST;
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_MAX_SLOTS) begin
         csr_prdata = {22'd0, max_slots_ff};
      end else begin
         csr_prdata = {30'd0, mode_ff};
      end
   end

   // next state and memory access for the accepted request, and register writes
   always_comb begin
      mode_in       = mode_ff;
      max_slots_in  = max_slots_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      mem_addr      = slot_index;
      ram_req.wr_en = 1'b0;
      ram_req.rd_en = 1'b0;
      ram_req.wdata = data_byte;
      s1_in         = '0;

      if (req_fire) begin
         unique case (action)
            ACT_HOST_WR: begin
               ram_req.wr_en = (slot_index <= SLOT_LAST);
            end
            ACT_HOST_RD: begin
               ram_req.rd_en = (slot_index <= SLOT_LAST);
               s1_in.rd_sel  = (slot_index <= SLOT_LAST);
            end
            ACT_TX_DONE: begin
               if (mode_ff == MODE_TX) begin
                  unique case (phase_ff)
                     PH_BREAK: begin
                        s1_in.tx_valid = 1'b1;
                        s1_in.brk      = 1'b1;
                        phase_in       = PH_START;
                     end
                     PH_START: begin
                        s1_in.tx_valid = 1'b1;
                        s1_in.tx_sel   = 1'b1;
                        ram_req.rd_en  = 1'b1;
                        mem_addr       = 10'd0;
                        count_in       = 10'd1;
                        phase_in       = PH_DATA;
                     end
                     PH_DATA: begin
                        s1_in.tx_valid = 1'b1;
                        s1_in.tx_sel   = (count_ff <= SLOT_LAST);
                        ram_req.rd_en  = (count_ff <= SLOT_LAST);
                        mem_addr       = count_ff;
                        count_in       = count_inc;
                        if (count_inc > max_slots_ff) begin
                           phase_in = PH_BREAK;
                        end
                     end
                     PH_IDLE: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
            ACT_RX_BYTE: begin
               if (mode_ff == MODE_RX) begin
                  if (frame_error) begin
                     // a break closes the frame
                     phase_in    = PH_BREAK;
                     count_in    = 10'd0;
                     s1_in.done  = (count_ff != 10'd0);
                     s1_in.slots = count_ff;
                  end else begin
                     unique case (phase_ff)
                        PH_BREAK: begin
                           if (data_byte == 8'h00) begin
                              phase_in = PH_DATA;
                              count_in = 10'd1;
                           end else begin
                              phase_in = PH_IDLE;
                           end
                        end
                        PH_DATA: begin
                           ram_req.wr_en = (count_ff <= SLOT_LAST);
                           mem_addr      = count_ff;
                           count_in      = count_inc;
                           if (count_inc > SLOT_LAST) begin
                              phase_in = PH_IDLE;
                           end
                        end
                        PH_START, PH_IDLE: begin
                           phase_in = phase_ff;
                        end
                     endcase
                  end
               end
            end
         endcase
      end

      if (cfg_wr) begin
         if (csr_paddr[2] == REG_MODE) begin
            mode_in  = csr_pwdata[1:0];
            count_in = 10'd0;
            phase_in = (csr_pwdata[1:0] == MODE_RX) ? PH_IDLE : PH_BREAK;
         end else begin
            max_slots_in = cfg_slots;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         max_slots_ff <= SLOTS_RST;
         phase_ff     <= PH_BREAK;
         count_ff     <= 10'd0;
      end else begin
         mode_ff      <= mode_in;
         max_slots_ff <= max_slots_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
      end
   end

   dmxft_slot_ram #(
      .SLOT_COUNT (SLOT_COUNT),
      .AW         (AW)
   ) u_slot_ram (
      .clock    (clock),
      .reset    (reset),
      .req      (ram_req),
      .addr     (mem_addr[AW-1:0]),
      .rdata    (ram_rdata),
      .clr_busy (clr_busy)
   );

   // read stage and output register
   assign rd_val = s1_ff.rd_sel ? ram_rdata : 8'h00;
   assign tx_val = s1_ff.tx_sel ? ram_rdata : 8'h00;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_data_in  = {3'b000, s1_ff.slots, s1_ff.done, s1_ff.brk,
                         tx_val, s1_ff.tx_valid, rd_val};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `DMXFT_ASSERT_IMPLIES(a_no_request_in_clear, clock, reset, clr_busy, !req_tready)
   `DMXFT_ASSERT_NEXT(a_read_stage_holds, clock, reset,
      s1_valid_ff && out_valid_ff && !rsp_tready, s1_valid_ff)
   `DMXFT_ASSERT_IMPLIES(a_done_has_slots, clock, reset,
      out_valid_ff && out_data_ff[18], out_data_ff[28:19] != 10'd0)

endmodule

// ----- src/dmxft_slot_ram.sv -----
// Slot buffer memory with a clearing sweep after reset.
module dmxft_slot_ram #(
   parameter int SLOT_COUNT = dmxft_pkg::SLOT_COUNT_DEFAULT,
   parameter int AW         = $clog2(SLOT_COUNT + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dmxft_pkg::ram_req_type    req,
   input  logic [AW-1:0]             addr,
   output logic [7:0]                rdata,
   output logic                      clr_busy
);
   import dmxft_pkg::*;

   localparam int DEPTH = SLOT_COUNT + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [7:0]    slot_mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clr_busy_ff;
   logic          clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         slot_mem[clr_addr_ff] <= 8'h00;
      end else if (req.wr_en) begin
         slot_mem[addr] <= req.wdata;
      end
   end

   // hold the read data until the next read
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rdata_ff <= slot_mem[addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the DMX512 frame transceiver: table-driven directed part, then random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmxft_pkg::*;

   localparam int SLOTS           = SLOT_COUNT_DEFAULT;
   localparam int RANDOM_REQUESTS = 250;
   localparam int MAX_REPORTS     = 10;
   // 3 decodes as disabled, just like 0
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // matches rsp_tdata bit for bit, lowest field last
   typedef struct packed {
      logic [2:0] pad;
      logic [9:0] frame_slots;
      logic       frame_done;
      logic       break_format;
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic [7:0] read_data;
   } dmx_result_type;

   localparam dmx_result_type QUIET = '0;

   typedef struct {
      bit             is_cfg;
      logic           reg_sel;
      logic [31:0]    reg_val;
      action_type     act;
      logic [9:0]     idx;
      logic [7:0]     data;
      logic           ferr;
      bit             fixed;
      dmx_result_type want;
   } step_row_type;

   typedef enum logic [1:0] {
      RDY_OPEN,
      RDY_LIGHT,
      RDY_HEAVY,
      RDY_TOGGLE
   } ready_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // slot_index[9:0], data_byte[17:10], frame_error[18], zero
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                  // break_format[17], frame_done[18], frame_slots[28:19], zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [7:0]  slot_image [0:SLOTS];
   phase_type   line_phase;
   logic [9:0]  slot_cnt;
   logic [1:0]  line_mode;
   logic [9:0]  max_slots_now;

   dmx_result_type  pending_results [$];
   step_row_type    directed_plan [$];
   int              requests_sent = 0;
   int              directed_count = 0;
   int              results_seen = 0;
   int              mismatches = 0;
   int              reg_writes = 0;
   int              frames_closed = 0;
   int              tx_bytes = 0;
   int              burst_left = 0;
   int              stall_left = 0;
   ready_style_type stall_style = RDY_OPEN;

   dmx512_frame_transceiver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] stored(input logic [9:0] idx);
      return (idx <= SLOTS) ? slot_image[idx] : 8'h00;
   endfunction

   // advance the line sequence by one request and return what it produces
   function automatic dmx_result_type transceive_step(input action_type act,
                                                      input logic [9:0] idx,
                                                      input logic [7:0] data, input logic ferr);
      dmx_result_type r;
      r = QUIET;
      case (act)
         ACT_HOST_WR: begin
            if (idx <= SLOTS) slot_image[idx] = data;
         end
         ACT_HOST_RD: begin
            r.read_data = stored(idx);
         end
         ACT_TX_DONE: begin
            if (line_mode == MODE_TX) begin
               case (line_phase)
                  PH_BREAK: begin
                     r.tx_valid     = 1'b1;
                     r.break_format = 1'b1;
                     line_phase     = PH_START;
                  end
                  PH_START: begin
                     r.tx_valid = 1'b1;
                     r.tx_byte  = stored(10'd0);
                     slot_cnt   = 10'd1;
                     line_phase = PH_DATA;
                  end
                  PH_DATA: begin
                     r.tx_valid = 1'b1;
                     r.tx_byte  = stored(slot_cnt);
                     slot_cnt   = slot_cnt + 10'd1;
                     if (slot_cnt > max_slots_now) line_phase = PH_BREAK;
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            if (line_mode == MODE_RX) begin
               if (ferr) begin
                  line_phase = PH_BREAK;
                  if (slot_cnt != 10'd0) begin
                     r.frame_done  = 1'b1;
                     r.frame_slots = slot_cnt;
                  end
                  slot_cnt = 10'd0;
               end else if (line_phase == PH_BREAK) begin
                  // only a zero start code opens capture
                  if (data == 8'h00) begin
                     line_phase = PH_DATA;
                     slot_cnt   = 10'd1;
                  end else begin
                     line_phase = PH_IDLE;
                  end
               end else if (line_phase == PH_DATA) begin
                  if (slot_cnt <= SLOTS) slot_image[slot_cnt] = data;
                  slot_cnt = slot_cnt + 10'd1;
                  if (slot_cnt > SLOTS) line_phase = PH_IDLE;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic void apply_reg(input logic sel, input logic [31:0] val);
      logic [9:0] v;
      if (sel == REG_MODE) begin
         line_mode  = val[1:0];
         slot_cnt   = 10'd0;
         line_phase = (line_mode == MODE_RX) ? PH_IDLE : PH_BREAK;
      end else begin
         v = val[9:0];
         if (v < MIN_SLOTS) v = 10'(MIN_SLOTS);
         if (v > SLOTS) v = 10'(SLOTS);
         max_slots_now = v;
      end
   endfunction

   function automatic dmx_result_type mk_res(input logic [7:0] rd, input logic txv,
                                             input logic [7:0] txb, input logic brk,
                                             input logic done, input logic [9:0] cnt);
      dmx_result_type r;
      r              = QUIET;
      r.read_data    = rd;
      r.tx_valid     = txv;
      r.tx_byte      = txb;
      r.break_format = brk;
      r.frame_done   = done;
      r.frame_slots  = cnt;
      return r;
   endfunction

   function automatic void plan_cfg(input logic sel, input logic [31:0] val);
      step_row_type row;
      row         = '{act: ACT_HOST_WR, default: '0};
      row.is_cfg  = 1'b1;
      row.reg_sel = sel;
      row.reg_val = val;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_req(input action_type act, input logic [9:0] idx,
                                    input logic [7:0] data, input logic ferr,
                                    input bit fixed, input dmx_result_type want);
      step_row_type row;
      row       = '{act: ACT_HOST_WR, default: '0};
      row.act   = act;
      row.idx   = idx;
      row.data  = data;
      row.ferr  = ferr;
      row.fixed = fixed;
      row.want  = want;
      directed_plan.push_back(row);
   endfunction

   // mostly low slots so reads hit captured data, sometimes anywhere in the index range
   function automatic logic [9:0] pick_slot();
      return ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, 40))
                                          : 10'($urandom_range(0, 1023));
   endfunction

   task automatic drive_request(input action_type act, input logic [9:0] idx,
                                input logic [7:0] data, input logic ferr,
                                input bit fixed, input dmx_result_type want);
      dmx_result_type model;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'd0, ferr, data, idx};
      do @(posedge clock); while (!req_tready);
      model = transceive_step(act, idx, data, ferr);
      pending_results.push_back(fixed ? want : model);
      requests_sent++;
   endtask

   task automatic send_any(input action_type act, input logic [9:0] idx,
                           input logic [7:0] data, input logic ferr);
      drive_request(act, idx, data, ferr, 1'b0, QUIET);
   endtask

   // drain the result stream before touching a register
   task automatic write_reg(input logic sel, input logic [31:0] val);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_reg(sel, val);
      reg_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_tx_phase(input logic [31:0] max_val, input int frames, input int cap);
      int n;
      int r;
      write_reg(REG_MAX_SLOTS, max_val);
      write_reg(REG_MODE, {30'd0, MODE_TX});
      n = frames * (int'(max_slots_now) + 2) + $urandom_range(0, 6);
      if (n > cap) n = cap;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 88)
            send_any(ACT_TX_DONE, pick_slot(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else if (r < 93)
            send_any(ACT_HOST_WR, pick_slot(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else if (r < 97)
            send_any(ACT_HOST_RD, pick_slot(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else
            send_any(ACT_RX_BYTE, pick_slot(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_rx_phase(input int frames, input bit big);
      int len;
      int r;
      write_reg(REG_MODE, {30'd0, MODE_RX});
      repeat (frames) begin
         // now and then drop the break to feed a broken frame
         if ($urandom_range(0, 9) != 0)
            send_any(ACT_RX_BYTE, pick_slot(), 8'($urandom_range(0, 255)), 1'b1);
         send_any(ACT_RX_BYTE, pick_slot(),
                  ($urandom_range(0, 4) != 0) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
         len = big ? SLOTS + 3 : $urandom_range(0, 30);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (big || r < 90)
               send_any(ACT_RX_BYTE, pick_slot(), 8'($urandom_range(0, 255)),
                        !big && ($urandom_range(0, 99) == 0));
            else if (r < 94)
               send_any(ACT_HOST_RD, pick_slot(), 8'($urandom_range(0, 255)), 1'b0);
            else if (r < 97)
               send_any(ACT_HOST_WR, pick_slot(), 8'($urandom_range(0, 255)), 1'b0);
            else
               send_any(ACT_TX_DONE, pick_slot(), 8'($urandom_range(0, 255)), 1'b0);
         end
      end
      // close the last frame so its count is reported
      send_any(ACT_RX_BYTE, pick_slot(), 8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(2, 8))
         send_any(ACT_HOST_RD, 10'($urandom_range(0, 40)), 8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic run_off_phase();
      write_reg(REG_MODE, {30'd0, ($urandom_range(0, 1) != 0) ? MODE_SPARE : MODE_OFF});
      write_reg(REG_MAX_SLOTS, $urandom_range(0, 1023));
      repeat ($urandom_range(8, 16))
         send_any(action_type'($urandom_range(0, 3)), pick_slot(),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic report_mismatch(input string what, input dmx_result_type want,
                                  input dmx_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ns %s: expected rd=%02h txv=%0b txb=%02h brk=%0b done=%0b slots=%0d pad=%0h",
                  $realtime, what, want.read_data, want.tx_valid, want.tx_byte,
                  want.break_format, want.frame_done, want.frame_slots, want.pad,
                  "\n      got      rd=%02h txv=%0b txb=%02h brk=%0b done=%0b slots=%0d pad=%0h",
                  got.read_data, got.tx_valid, got.tx_byte, got.break_format,
                  got.frame_done, got.frame_slots, got.pad);
   endtask

   // receiver: stall in stretches of changing style
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = ready_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(8, 80);
      end
      stall_left--;
      case (stall_style)
         RDY_OPEN:  rsp_tready <= 1'b1;
         RDY_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         RDY_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:   rsp_tready <= stall_left[1];
      endcase
   end

   always @(posedge clock) begin : rsp_check
      dmx_result_type got;
      dmx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = dmx_result_type'(rsp_tdata);
         results_seen++;
         if (got.frame_done) frames_closed++;
         if (got.tx_valid) tx_bytes++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", QUIET, got);
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
                got.tx_byte !== want.tx_byte || got.break_format !== want.break_format ||
                got.frame_done !== want.frame_done || got.frame_slots !== want.frame_slots ||
                got.pad !== want.pad)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      int base;
      slot_image    = '{default: 8'h00};
      line_phase    = PH_BREAK;
      slot_cnt      = '0;
      line_mode     = MODE_OFF;
      max_slots_now = 10'(SLOTS);

      // idle after reset, range edges of the slot store
      plan_req(ACT_HOST_RD, 10'd0,    8'h00, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_RD, 10'd512,  8'hFF, 1'b1, 1'b1, QUIET);
      plan_req(ACT_HOST_WR, 10'd0,    8'hFF, 1'b1, 1'b1, QUIET);
      plan_req(ACT_HOST_WR, 10'd512,  8'hA5, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_WR, 10'd1023, 8'h77, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_RD, 10'd1023, 8'h00, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_RD, 10'd513,  8'h00, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_RD, 10'd0,    8'h00, 1'b0, 1'b1,
               mk_res(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 10'd0));
      plan_req(ACT_HOST_RD, 10'd512,  8'h00, 1'b0, 1'b1,
               mk_res(8'hA5, 1'b0, 8'h00, 1'b0, 1'b0, 10'd0));
      // line events while disabled
      plan_req(ACT_TX_DONE, 10'd3,    8'h11, 1'b0, 1'b1, QUIET);
      plan_req(ACT_RX_BYTE, 10'd3,    8'h22, 1'b1, 1'b1, QUIET);
      // transmit with max_slots below the floor
      plan_cfg(REG_MAX_SLOTS, 32'd0);
      plan_cfg(REG_MODE, {30'd0, MODE_TX});
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b1,
               mk_res(8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 10'd0));
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b1,
               mk_res(8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, 10'd0));
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b0, QUIET);
      plan_req(ACT_RX_BYTE, 10'd0,    8'h00, 1'b1, 1'b1, QUIET);
      // receive: empty break, short frame, foreign start code
      plan_cfg(REG_MODE, {30'd0, MODE_RX});
      plan_req(ACT_RX_BYTE, 10'd0,    8'h00, 1'b1, 1'b1, QUIET);
      plan_req(ACT_RX_BYTE, 10'd0,    8'h00, 1'b0, 1'b0, QUIET);
      plan_req(ACT_RX_BYTE, 10'd0,    8'h12, 1'b0, 1'b0, QUIET);
      plan_req(ACT_RX_BYTE, 10'd0,    8'h34, 1'b1, 1'b1,
               mk_res(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 10'd2));
      plan_req(ACT_RX_BYTE, 10'd0,    8'h55, 1'b0, 1'b0, QUIET);
      plan_req(ACT_RX_BYTE, 10'd0,    8'h00, 1'b0, 1'b0, QUIET);
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b1, QUIET);
      plan_req(ACT_HOST_RD, 10'd1,    8'h00, 1'b0, 1'b0, QUIET);
      // spare mode value stays disabled
      plan_cfg(REG_MODE, {30'd0, MODE_SPARE});
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b1, QUIET);
      plan_cfg(REG_MAX_SLOTS, 32'd1023);
      plan_cfg(REG_MODE, {30'd0, MODE_OFF});
      plan_req(ACT_TX_DONE, 10'd0,    8'h00, 1'b0, 1'b1, QUIET);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg)
            write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_val);
         else
            drive_request(directed_plan[i].act, directed_plan[i].idx, directed_plan[i].data,
                          directed_plan[i].ferr, directed_plan[i].fixed, directed_plan[i].want);
      end
      directed_count = requests_sent;

      // one full capture, then transmit traffic with max_slots at 512
      run_rx_phase(1, 1'b1);
      run_tx_phase(32'd512, 1, 600);

      base = requests_sent;
      while (requests_sent - base < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 4))
            0:       run_off_phase();
            1, 2:    run_tx_phase(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                             : $urandom_range(18, 40),
                                  $urandom_range(1, 3), 120);
            default: run_rx_phase($urandom_range(1, 4), 1'b0);
         endcase
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests (%0d directed) with %0d register writes; %0d results checked.",
               requests_sent, directed_count, reg_writes, results_seen);
      $display("Saw %0d transmit bytes and %0d closed receive frames; %0d mismatches, %0d left over.",
               tx_bytes, frames_closed, mismatches, pending_results.size());
      if (mismatches == 0 && pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
